// File: src/tpe_pkg.sv
// Shared widths, record types and the coordinate helper of the triangle plane unit.
// No dependencies; every other file in src uses it by scoped names.
`default_nettype none
package tpe_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int IN_W = 32;
	localparam int TAG_W = 24;
	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = PROD_W;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int NORM_FRAC = 30;
	localparam int NORM_W = 32;
	localparam int ROOT_BITS = NORM_FRAC + 1;
	localparam int RES_W = SUM_W + 2 * ROOT_BITS + 3;
	localparam int DOT_PROD_W = NORM_W + COORD_WIDTH;
	localparam int DOT_W = DOT_PROD_W + 2;
	localparam int RND_W = DOT_W - NORM_FRAC + 1;
	localparam int OFS_W = 41;
	localparam int CMP_W = RND_W + OFS_W;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [2:0][COORD_WIDTH-1:0] a;
	} tpe_carry_t;

	typedef struct packed {
		tpe_carry_t car;
		logic [2:0] neg;
		logic degen;
	} tpe_pass_t;

	// residual, scaled u*S and scaled S for the bit being decided
	typedef struct packed {
		logic [2:0][RES_W-1:0] r;
		logic [2:0][RES_W-1:0] ps;
		logic [RES_W-1:0] ss;
		logic [2:0][ROOT_BITS-1:0] m;
		tpe_pass_t pass;
	} tpe_root_t;

	function automatic logic [COORD_WIDTH-1:0] coord(input logic [IN_W-1:0] v);
		logic [COORD_WIDTH+IN_W-1:0] t;
		t = {{COORD_WIDTH{1'b0}}, v};
		return t[COORD_WIDTH-1:0];
	endfunction
endpackage
`default_nettype wire

// File: src/tpe_front.sv
// Front end: edges, cross product, squared magnitudes, their sum and the root seed.
// Depends on tpe_pkg.
`default_nettype none
module tpe_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [tpe_pkg::TAG_W-1:0] tag_in,
	input  wire logic [2:0][tpe_pkg::IN_W-1:0] a_in,
	input  wire logic [2:0][tpe_pkg::IN_W-1:0] b_in,
	input  wire logic [2:0][tpe_pkg::IN_W-1:0] c_in,
	output logic valid_out,
	output tpe_pkg::tpe_root_t d_out,
	input  wire logic ready_in
);
	localparam int CW = tpe_pkg::COORD_WIDTH;
	localparam int EW = tpe_pkg::EDGE_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	tpe_pkg::tpe_carry_t car_s1, car_s2, car_s3, car_s4, car_s5, car_s6, car_s7;
	logic [2:0][EW-1:0] e1_s1, e2_s1;
	logic [2:0][tpe_pkg::PROD_W-1:0] p_s2, q_s2;
	logic [2:0][tpe_pkg::CROSS_W-1:0] x_s3;
	logic [2:0][tpe_pkg::MAG_W-1:0] mag_s4;
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7;
	logic [2:0][2*EW-1:0] hh_s5, hl_s5, ll_s5;
	logic [2:0][tpe_pkg::SQ_W-1:0] sq_s6, sq_s7;
	logic [tpe_pkg::SUM_W-1:0] sum_s7;
	tpe_pkg::tpe_root_t d_s8;

	logic [2:0][tpe_pkg::COORD_WIDTH-1:0] a_c, b_c, c_c;
	logic [2:0][EW-1:0] e1_c, e2_c;
	logic [2:0][tpe_pkg::PROD_W-1:0] p_c, q_c;
	logic [2:0][tpe_pkg::CROSS_W-1:0] x_c, xn_c;
	logic [2:0][tpe_pkg::SQ_W-1:0] sq_c;
	logic [tpe_pkg::SUM_W-1:0] sum_c;
	tpe_pkg::tpe_root_t seed_c;
	logic [tpe_pkg::RES_W-1:0] s_ext;

	assign rdy_s8 = !v_s8 || ready_in;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign valid_out = v_s8;
	assign d_out = d_s8;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_c[j] = tpe_pkg::coord(a_in[j]);
			b_c[j] = tpe_pkg::coord(b_in[j]);
			c_c[j] = tpe_pkg::coord(c_in[j]);
			e1_c[j] = {c_c[j][CW-1], c_c[j]} - {b_c[j][CW-1], b_c[j]};
			e2_c[j] = {a_c[j][CW-1], a_c[j]} - {b_c[j][CW-1], b_c[j]};
			x_c[j] = {p_s2[j][tpe_pkg::PROD_W-1], p_s2[j]}
				- {q_s2[j][tpe_pkg::PROD_W-1], q_s2[j]};
			xn_c[j] = tpe_pkg::CROSS_W'(0) - x_s3[j];
			sq_c[j] = {hh_s5[j], ll_s5[j]} + (tpe_pkg::SQ_W'(hl_s5[j]) << (EW + 1));
		end
		sum_c = tpe_pkg::SUM_W'(sq_s6[0]) + tpe_pkg::SUM_W'(sq_s6[1])
			+ tpe_pkg::SUM_W'(sq_s6[2]);
		s_ext = tpe_pkg::RES_W'(sum_s7);
		seed_c.ss = s_ext << (2 * tpe_pkg::NORM_FRAC + 2);
		for (int j = 0; j < 3; j++) begin
			seed_c.r[j] = (tpe_pkg::RES_W'(sq_s7[j]) << (2 * tpe_pkg::ROOT_BITS)) - s_ext;
			seed_c.ps[j] = tpe_pkg::RES_W'(0) - (s_ext << (tpe_pkg::NORM_FRAC + 2));
			seed_c.m[j] = '0;
		end
		seed_c.pass.car = car_s7;
		seed_c.pass.neg = neg_s7;
		seed_c.pass.degen = (sum_s7 == '0);
	end

	// cross product terms: X_j = e1[j+1]*e2[j+2] - e1[j+2]*e2[j+1]
	for (genvar j = 0; j < 3; j++) begin : g_cross
		assign p_c[j] = $signed(e1_s1[(j+1)%3]) * $signed(e2_s1[(j+2)%3]);
		assign q_c[j] = $signed(e1_s1[(j+2)%3]) * $signed(e2_s1[(j+1)%3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			car_s1.tag <= tag_in;
			car_s1.a <= a_c;
			e1_s1 <= e1_c;
			e2_s1 <= e2_c;
		end
		if (rdy_s2) begin
			car_s2 <= car_s1;
			p_s2 <= p_c;
			q_s2 <= q_c;
		end
		if (rdy_s3) begin
			car_s3 <= car_s2;
			x_s3 <= x_c;
		end
		if (rdy_s4) begin
			car_s4 <= car_s3;
			for (int j = 0; j < 3; j++) begin
				neg_s4[j] <= x_s3[j][tpe_pkg::CROSS_W-1];
				mag_s4[j] <= x_s3[j][tpe_pkg::CROSS_W-1] ? xn_c[j][tpe_pkg::MAG_W-1:0]
					: x_s3[j][tpe_pkg::MAG_W-1:0];
			end
		end
		if (rdy_s5) begin
			car_s5 <= car_s4;
			neg_s5 <= neg_s4;
			for (int j = 0; j < 3; j++) begin
				hh_s5[j] <= mag_s4[j][2*EW-1:EW] * mag_s4[j][2*EW-1:EW];
				hl_s5[j] <= mag_s4[j][2*EW-1:EW] * mag_s4[j][EW-1:0];
				ll_s5[j] <= mag_s4[j][EW-1:0] * mag_s4[j][EW-1:0];
			end
		end
		if (rdy_s6) begin
			car_s6 <= car_s5;
			neg_s6 <= neg_s5;
			sq_s6 <= sq_c;
		end
		if (rdy_s7) begin
			car_s7 <= car_s6;
			neg_s7 <= neg_s6;
			sq_s7 <= sq_s6;
			sum_s7 <= sum_c;
		end
		if (rdy_s8) d_s8 <= seed_c;
	end
endmodule
`default_nettype wire

// File: src/tpe_root_cell.sv
// One cell of the normalising chain: decides one bit of each rounded normal component.
// Depends on tpe_pkg.
`default_nettype none
module tpe_root_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_in,
	input  wire tpe_pkg::tpe_root_t d_in,
	output logic ready_out,
	output logic valid_out,
	output tpe_pkg::tpe_root_t d_out,
	input  wire logic ready_in
);
	localparam int RW = tpe_pkg::RES_W;

	logic v_q;
	tpe_pkg::tpe_root_t d_q, nxt;

	assign ready_out = !v_q || ready_in;
	assign valid_out = v_q;
	assign d_out = d_q;

	// trial keeps the residual T - (2m-1)^2 S; accept when it stays non-negative
	always_comb begin
		logic [RW-1:0] trial, ps_new;
		logic acc;
		nxt = d_in;
		for (int j = 0; j < 3; j++) begin
			trial = d_in.r[j] - d_in.ps[j] - d_in.ss;
			acc = !trial[RW-1];
			ps_new = acc ? d_in.ps[j] + (d_in.ss << 1) : d_in.ps[j];
			nxt.r[j] = acc ? trial : d_in.r[j];
			nxt.ps[j] = {ps_new[RW-1], ps_new[RW-1:1]};
			nxt.m[j] = {d_in.m[j][tpe_pkg::ROOT_BITS-2:0], acc};
		end
		nxt.ss = {2'b00, d_in.ss[RW-1:2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_out) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out) d_q <= nxt;
	end
endmodule
`default_nettype wire

// File: src/tpe_back.sv
// Back end: signed normal, dot with vertex A, rounding, saturation and output register.
// Depends on tpe_pkg.
`default_nettype none
module tpe_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_in,
	input  wire tpe_pkg::tpe_root_t d_in,
	output logic ready_out,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [tpe_pkg::TAG_W-1:0] tag_q,
	output logic [2:0][tpe_pkg::NORM_W-1:0] normal_q,
	output logic [tpe_pkg::OFS_W-1:0] offset_q,
	output logic degen_q
);
	localparam int NW = tpe_pkg::NORM_W;
	localparam int DW = tpe_pkg::DOT_W;
	localparam int CMPW = tpe_pkg::CMP_W;
	localparam logic [CMPW-1:0] LIM = CMPW'(1) << (tpe_pkg::OFS_W - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_q;
	tpe_pkg::tpe_carry_t car_s1;
	logic [tpe_pkg::TAG_W-1:0] tag_s2, tag_s3, tag_s4, tag_s5;
	logic [2:0][NW-1:0] n_s1, n_s2, n_s3, n_s4, n_s5;
	logic degen_s1, degen_s2, degen_s3, degen_s4, degen_s5;
	logic [2:0][tpe_pkg::DOT_PROD_W-1:0] prod_s2;
	logic [DW-1:0] dot_s3;
	logic [DW-1:0] mag_s4;
	logic neg_s4, neg_s5;
	logic [tpe_pkg::RND_W-1:0] rnd_s5;

	logic [2:0][NW-1:0] n_c;
	logic [2:0][tpe_pkg::DOT_PROD_W-1:0] prod_c;
	logic [DW:0] half_sum;
	logic [CMPW-1:0] rnd_ext, ofs_c;

	assign rdy_q = !v_q || !out_stall;
	assign rdy_s5 = !v_s5 || rdy_q;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign ready_out = rdy_s1;
	assign out_valid = v_q;

	always_comb begin
		logic [NW-1:0] lo;
		for (int j = 0; j < 3; j++) begin
			lo = {{(NW - tpe_pkg::ROOT_BITS){1'b0}}, d_in.m[j]};
			if (d_in.pass.degen) n_c[j] = '0;
			else if (d_in.pass.neg[j]) n_c[j] = NW'(0) - lo;
			else n_c[j] = lo;
			prod_c[j] = $signed(n_s1[j]) * $signed(car_s1.a[j]);
		end
		half_sum = {1'b0, mag_s4} + ((DW + 1)'(1) << (tpe_pkg::NORM_FRAC - 1));
		rnd_ext = CMPW'(rnd_s5);
		// dot negative gives a positive offset
		if (neg_s5) ofs_c = (rnd_ext > LIM - 1'b1) ? LIM - 1'b1 : rnd_ext;
		else ofs_c = CMPW'(0) - ((rnd_ext > LIM) ? LIM : rnd_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= valid_in;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_q) v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			car_s1 <= d_in.pass.car;
			n_s1 <= n_c;
			degen_s1 <= d_in.pass.degen;
		end
		if (rdy_s2) begin
			tag_s2 <= car_s1.tag;
			n_s2 <= n_s1;
			degen_s2 <= degen_s1;
			prod_s2 <= prod_c;
		end
		if (rdy_s3) begin
			tag_s3 <= tag_s2;
			n_s3 <= n_s2;
			degen_s3 <= degen_s2;
			dot_s3 <= DW'($signed(prod_s2[0])) + DW'($signed(prod_s2[1]))
				+ DW'($signed(prod_s2[2]));
		end
		if (rdy_s4) begin
			tag_s4 <= tag_s3;
			n_s4 <= n_s3;
			degen_s4 <= degen_s3;
			neg_s4 <= dot_s3[DW-1];
			mag_s4 <= dot_s3[DW-1] ? DW'(0) - dot_s3 : dot_s3;
		end
		if (rdy_s5) begin
			tag_s5 <= tag_s4;
			n_s5 <= n_s4;
			degen_s5 <= degen_s4;
			neg_s5 <= neg_s4;
			rnd_s5 <= half_sum[DW:tpe_pkg::NORM_FRAC];
		end
		if (rdy_q) begin
			tag_q <= tag_s5;
			normal_q <= n_s5;
			degen_q <= degen_s5;
			offset_q <= ofs_c[tpe_pkg::OFS_W-1:0];
		end
	end
endmodule
`default_nettype wire

// File: src/triangle_plane_equation.sv
// Triangle unit normal and plane offset. Pipeline from input transaction to
// out_valid: 8 front stages, 31 root cells at one bit each, 6 back stages.
// Throughput: one triangle per cycle while out_stall is low; every stage and every root
// cell holds one triangle, and the 31-cell bit-decision chain sets the depth.
// Reset: asynchronous, clears all stage valid bits; the pipeline comes up empty.
`default_nettype none
module triangle_plane_equation (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [23:0] triangle_index,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [31:0] b_z,
	input  wire logic signed [31:0] c_x,
	input  wire logic signed [31:0] c_y,
	input  wire logic signed [31:0] c_z,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [23:0] tag_out,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [31:0] normal_z,
	output logic signed [40:0] plane_offset,
	output logic degenerate
);
	localparam int NB = tpe_pkg::ROOT_BITS;

	tpe_pkg::tpe_root_t chain_d [NB+1];
	logic chain_v [NB+1];
	logic chain_r [NB+1];
	logic [2:0][tpe_pkg::NORM_W-1:0] normal;

	tpe_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.tag_in(triangle_index),
		.a_in({a_z, a_y, a_x}), .b_in({b_z, b_y, b_x}), .c_in({c_z, c_y, c_x}),
		.valid_out(chain_v[0]), .d_out(chain_d[0]), .ready_in(chain_r[0])
	);

	for (genvar i = 0; i < NB; i++) begin : g_cell
		tpe_root_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_in(chain_v[i]), .d_in(chain_d[i]), .ready_out(chain_r[i]),
			.valid_out(chain_v[i+1]), .d_out(chain_d[i+1]), .ready_in(chain_r[i+1])
		);
	end

	tpe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.valid_in(chain_v[NB]), .d_in(chain_d[NB]), .ready_out(chain_r[NB]),
		.out_valid(out_valid), .out_stall(out_stall),
		.tag_q(tag_out), .normal_q(normal), .offset_q(plane_offset),
		.degen_q(degenerate)
	);

	assign normal_x = normal[0];
	assign normal_y = normal[1];
	assign normal_z = normal[2];

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
			&& plane_offset == 0)
		else $error("degenerate transaction with nonzero result");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824
			&& normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824
			&& normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
		else $error("normal component beyond unit range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side can take a transaction");
endmodule
`default_nettype wire
